FILE: rtl/core/tta_pkg.sv
// Shared types, constants and helper functions for the toroidal turning ant block.
package tta_pkg;

  // Size of the cell store, in columns and rows.
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;

  // Largest board in use along each axis; the position fields are eight bits wide.
  localparam int DIM_TOP_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int DIM_TOP_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Configuration register indices.
  typedef enum logic [1:0] {
    CFG_BOARD_WIDTH  = 2'd0,
    CFG_BOARD_HEIGHT = 2'd1,
    CFG_START_COL    = 2'd2,
    CFG_START_ROW    = 2'd3
  } cfg_reg_t;

  // Request codes.
  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Ant heading; turning right adds one, turning left subtracts one.
  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_MOVE,
    ST_FLIP,
    ST_RD_ISSUE,
    ST_RD_PICK,
    ST_DONE
  } tta_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clr_en;    // write zero at the clearing address and advance it
    logic capture;   // latch the request fields
    logic place;     // put the ant on the start cell and mark that cell
    logic move;      // advance the position and read the new cell
    logic flip;      // turn, flip the cell under the ant
    logic rd_issue;  // read the requested cell
    logic pick;      // take the read data as the result value
    logic load_out;  // load the result register
  } tta_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clr_last;  // clearing address is at the last entry
    logic placed;    // ant has been placed since reset
    logic req_read;  // latched request is a cell read
  } tta_status_t;

  // Clamp a position to the last index of a dimension of size n.
  function automatic logic [7:0] clamp_pos(input logic [7:0] p, input logic [8:0] n);
    logic [8:0] last;
    last = n - 9'd1;
    clamp_pos = ({1'b0, p} >= n) ? last[7:0] : p;
  endfunction

  // Limit a configured dimension to the range 1 .. top.
  function automatic logic [8:0] limit_dim(input logic [8:0] v, input logic [8:0] top);
    if (v == 9'd0) begin
      limit_dim = 9'd1;
    end else if (v > top) begin
      limit_dim = top;
    end else begin
      limit_dim = v;
    end
  endfunction

  // Linear address of a cell, row by row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] col, input logic [7:0] row);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

endpackage

FILE: rtl/core/tta_ctrl.sv
// Sequencer for the ant block: clearing pass, item dispatch and result handshake.
module tta_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 req_type,
  input  logic                 out_stall,
  input  tta_pkg::tta_status_t status,
  output logic                 in_stall,
  output logic                 out_valid,
  output tta_pkg::tta_cmd_t    cmd
);

  tta_pkg::tta_state_t state, state_next;
  logic                out_free;
  logic                out_valid_next;

  // The result register can take a new value when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != tta_pkg::ST_IDLE);

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tta_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      tta_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_next = tta_pkg::ST_IDLE;
        end
      end
      tta_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!status.placed) begin
            state_next = tta_pkg::ST_PLACE;
          end else if (req_type == tta_pkg::REQ_READ) begin
            state_next = tta_pkg::ST_RD_ISSUE;
          end else begin
            state_next = tta_pkg::ST_MOVE;
          end
        end
      end
      tta_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
        if (status.req_read) begin
          state_next = tta_pkg::ST_RD_ISSUE;
        end else begin
          state_next = tta_pkg::ST_MOVE;
        end
      end
      tta_pkg::ST_MOVE: begin
        cmd.move   = 1'b1;
        state_next = tta_pkg::ST_FLIP;
      end
      tta_pkg::ST_FLIP: begin
        cmd.flip = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tta_pkg::ST_IDLE;
        end else begin
          state_next = tta_pkg::ST_DONE;
        end
      end
      tta_pkg::ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = tta_pkg::ST_RD_PICK;
      end
      tta_pkg::ST_RD_PICK: begin
        cmd.pick = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tta_pkg::ST_IDLE;
        end else begin
          state_next = tta_pkg::ST_DONE;
        end
      end
      tta_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tta_pkg::ST_IDLE;
      end
    endcase
  end

  // A result stays valid until its transfer completes.
  assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid && out_stall);

endmodule

FILE: rtl/core/tta_datapath.sv
// Datapath for the ant block: cell store, ant position and heading, result register.
module tta_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tta_pkg::tta_cmd_t            cmd,
  input  logic                         req_type,
  input  logic [7:0]                   read_col,
  input  logic [7:0]                   read_row,
  input  logic [8:0]                   width,
  input  logic [8:0]                   height,
  input  logic [7:0]                   start_col,
  input  logic [7:0]                   start_row,
  output tta_pkg::tta_status_t         status,
  output logic [7:0]                   ant_col,
  output logic [7:0]                   ant_row,
  output logic [1:0]                   heading,
  output logic                         cell_value
);

  // Cell store, one bit per cell.
  logic                       cell_mem [tta_pkg::MEM_DEPTH];
  logic                       mem_we;
  logic [tta_pkg::ADDR_W-1:0] mem_waddr;
  logic                       mem_wdata;
  logic                       mem_re;
  logic [tta_pkg::ADDR_W-1:0] mem_raddr;
  logic                       rdata;

  logic [tta_pkg::ADDR_W-1:0] clr_addr;
  logic                       placed;
  logic                       req_read;
  logic [7:0]                 req_col;
  logic [7:0]                 req_row;
  logic [7:0]                 pos_col;
  logic [7:0]                 pos_row;
  tta_pkg::heading_t          facing;
  tta_pkg::heading_t          facing_next;
  logic                       val;
  logic                       val_next;

  logic [7:0]                 place_col;
  logic [7:0]                 place_row;
  logic [7:0]                 cur_col;
  logic [7:0]                 cur_row;
  logic [7:0]                 last_col;
  logic [7:0]                 last_row;
  logic [8:0]                 width_m1;
  logic [8:0]                 height_m1;
  logic [7:0]                 move_col;
  logic [7:0]                 move_row;
  logic                       rd_in_range;

  assign status.clr_last = (clr_addr == tta_pkg::ADDR_W'(tta_pkg::MEM_DEPTH - 1));
  assign status.placed   = placed;
  assign status.req_read = req_read;

  // Start cell, clamped to the board in use.
  assign place_col = tta_pkg::clamp_pos(start_col, width);
  assign place_row = tta_pkg::clamp_pos(start_row, height);

  // Current position, clamped in case the board has shrunk under the ant.
  assign cur_col   = tta_pkg::clamp_pos(pos_col, width);
  assign cur_row   = tta_pkg::clamp_pos(pos_row, height);
  assign width_m1  = width - 9'd1;
  assign height_m1 = height - 9'd1;
  assign last_col  = width_m1[7:0];
  assign last_row  = height_m1[7:0];

  // One cell forward in the heading, wrapping at the board edges.
  always_comb begin
    move_col = cur_col;
    move_row = cur_row;
    case (facing)
      tta_pkg::HEAD_UP: begin
        move_row = (cur_row == 8'd0) ? last_row : cur_row - 8'd1;
      end
      tta_pkg::HEAD_RIGHT: begin
        move_col = (cur_col == last_col) ? 8'd0 : cur_col + 8'd1;
      end
      tta_pkg::HEAD_DOWN: begin
        move_row = (cur_row == last_row) ? 8'd0 : cur_row + 8'd1;
      end
      tta_pkg::HEAD_LEFT: begin
        move_col = (cur_col == 8'd0) ? last_col : cur_col - 8'd1;
      end
      default: begin
        move_col = cur_col;
      end
    endcase
  end

  // Cells beyond the store read as zero.
  assign rd_in_range = (32'(req_col) < 32'(tta_pkg::MAX_COLS)) &&
                       (32'(req_row) < 32'(tta_pkg::MAX_ROWS));

  // Turn right on a clear cell, left on a set one.
  always_comb begin
    facing_next = facing;
    if (cmd.flip) begin
      facing_next = rdata ? tta_pkg::heading_t'(facing - 2'd1)
                          : tta_pkg::heading_t'(facing + 2'd1);
    end
  end

  // Result value: the flipped cell for a step, the read cell for a read.
  always_comb begin
    val_next = val;
    if (cmd.flip) begin
      val_next = ~rdata;
    end else if (cmd.pick) begin
      val_next = rd_in_range & rdata;
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (cmd.clr_en) begin
      mem_we = 1'b1;
    end else if (cmd.place) begin
      mem_we    = 1'b1;
      mem_waddr = tta_pkg::cell_addr(place_col, place_row);
      mem_wdata = 1'b1;
    end else if (cmd.flip) begin
      mem_we    = 1'b1;
      mem_waddr = tta_pkg::cell_addr(pos_col, pos_row);
      mem_wdata = ~rdata;
    end
    mem_re    = cmd.move | cmd.rd_issue;
    mem_raddr = cmd.move ? tta_pkg::cell_addr(move_col, move_row)
                         : tta_pkg::cell_addr(req_col, req_row);
  end

  // Cell store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= cell_mem[mem_raddr];
    end
  end

  // Clearing address, placement flag and ant state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      placed   <= 1'b0;
      pos_col  <= 8'd0;
      pos_row  <= 8'd0;
      facing   <= tta_pkg::HEAD_UP;
    end else begin
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + tta_pkg::ADDR_W'(1);
      end
      if (cmd.place) begin
        placed  <= 1'b1;
        pos_col <= place_col;
        pos_row <= place_row;
        facing  <= tta_pkg::HEAD_UP;
      end else if (cmd.move) begin
        pos_col <= move_col;
        pos_row <= move_row;
      end else begin
        facing <= facing_next;
      end
    end
  end

  // Request latch and result value.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_read <= (req_type == tta_pkg::REQ_READ);
      req_col  <= read_col;
      req_row  <= read_row;
    end
    val <= val_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ant_col    <= pos_col;
      ant_row    <= pos_row;
      heading    <= facing_next;
      cell_value <= val_next;
    end
  end

endmodule

FILE: rtl/core/toroidal_turning_ant_step.sv
// Top level of the ant block: configuration registers, sequencer and datapath.
//
// Langton's ant on a wrapping board of one-bit cells. After reset the block
// clears its cell store (65536 entries, MAX_COLS times MAX_ROWS), one entry
// a cycle, with in_stall high; configuration writes are taken throughout.
// Then a step passes through ST_MOVE and ST_FLIP, a read through ST_RD_ISSUE
// and ST_RD_PICK; the result is loaded in the last if the output register
// is free, else from ST_DONE. The first item after reset also passes through
// ST_PLACE to place the ant. The input is taken again in the cycle after the
// result is loaded. The cell store has a synchronous read, so a step reads
// the new cell in ST_MOVE and writes it back flipped in ST_FLIP. One item is
// in work at a time. A finished result waits in the output register, and
// the block takes the next item meanwhile. Board width and height are held
// in 1..256. Start positions beyond the board are clamped to the last column
// or row, and take effect only at the first item after reset.
module toroidal_turning_ant_step (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] read_col,
  input  logic [7:0] read_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] ant_col,
  output logic [7:0] ant_row,
  output logic [1:0] heading,
  output logic       cell_value
);

  logic [8:0]           board_width;
  logic [8:0]           board_height;
  logic [7:0]           start_col;
  logic [7:0]           start_row;
  logic [8:0]           width;
  logic [8:0]           height;
  tta_pkg::tta_cmd_t    cmd;
  tta_pkg::tta_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= 9'd256;
      board_height <= 9'd256;
      start_col    <= 8'd0;
      start_row    <= 8'd0;
    end else if (cfg_write) begin
      case (tta_pkg::cfg_reg_t'(cfg_index))
        tta_pkg::CFG_BOARD_WIDTH:  board_width  <= cfg_data;
        tta_pkg::CFG_BOARD_HEIGHT: board_height <= cfg_data;
        tta_pkg::CFG_START_COL:    start_col    <= cfg_data[7:0];
        tta_pkg::CFG_START_ROW:    start_row    <= cfg_data[7:0];
        default: begin
          board_width <= board_width;
        end
      endcase
    end
  end

  // Board dimensions in use.
  assign width  = tta_pkg::limit_dim(board_width, 9'(tta_pkg::DIM_TOP_COLS));
  assign height = tta_pkg::limit_dim(board_height, 9'(tta_pkg::DIM_TOP_ROWS));

  tta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tta_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .read_col   (read_col),
    .read_row   (read_row),
    .width      (width),
    .height     (height),
    .start_col  (start_col),
    .start_row  (start_row),
    .status     (status),
    .ant_col    (ant_col),
    .ant_row    (ant_row),
    .heading    (heading),
    .cell_value (cell_value)
  );

endmodule
